// File: rtl/vva_pkg.sv
// Package for the velocity Verlet atom step: codes, types and Q16.16 helpers.
`timescale 1ns / 1ps

package vva_pkg;

    // Function codes carried with each atom
    typedef enum logic [1:0] {
        FUNC_DRIFT = 2'd0,
        FUNC_KICK  = 2'd1,
        FUNC_WRAP  = 2'd2,
        FUNC_PASS  = 2'd3
    } t_func;

    // Configuration register indexes
    localparam logic [1:0] REG_INV_MASS  = 2'd0;
    localparam logic [1:0] REG_TIME_STEP = 2'd1;
    localparam logic [1:0] REG_BOX_LEN   = 2'd2;
    localparam logic [1:0] REG_HALF_BOX  = 2'd3;

    localparam int unsigned PIPE_DEPTH = 5;

    localparam logic signed [31:0] Q_MAX = 32'sh7fff_ffff;
    localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;

    // Control from the top level to each axis datapath
    typedef struct packed {
        logic  en;     // pipeline advance
        t_func func;   // function code of the item in stage 4
    } t_axis_ctl;

    // Saturate a 33-bit signed sum to 32 bits
    function automatic logic signed [31:0] sat33(input logic signed [32:0] v);
        logic signed [31:0] r;
        if (v[32] != v[31]) begin
            r = v[32] ? Q_MIN : Q_MAX;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    // Saturate a 48-bit signed value to 32 bits
    function automatic logic signed [31:0] sat48(input logic signed [47:0] v);
        logic signed [31:0] r;
        if ((v[47:31] != 17'h0) && (v[47:31] != 17'h1ffff)) begin
            r = v[47] ? Q_MIN : Q_MAX;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    // Q16.16 product: exact, floor shift by 16, saturate
    function automatic logic signed [31:0] qmul(input logic signed [31:0] a,
                                                input logic signed [31:0] b);
        logic signed [63:0] p;
        p = a * b;
        return sat48(p[63:16]);
    endfunction

endpackage

// File: rtl/vva_axis.sv
// One axis of the velocity Verlet datapath: kick, drift and periodic wrap.
`timescale 1ns / 1ps

module vva_axis (
    input  logic                  i_clk,
    input  vva_pkg::t_axis_ctl    i_ctl,
    input  logic signed [31:0]    i_pos,
    input  logic signed [31:0]    i_vel,
    input  logic signed [31:0]    i_force,
    input  logic [30:0]           i_c,        // half-kick factor, aligned with stage 1
    input  logic [30:0]           i_dt,
    input  logic [30:0]           i_box,
    input  logic [30:0]           i_half,
    output logic signed [31:0]    o_new_pos,
    output logic signed [31:0]    o_new_vel
);

    logic signed [31:0] w_dt_s;
    logic signed [32:0] w_box33;
    logic signed [32:0] w_half33;
    logic signed [32:0] w_in_pos33;
    logic signed [32:0] w_r1_wrap33;
    logic signed [31:0] n_wrap1;
    logic signed [31:0] n_wrap2;
    logic signed [31:0] n_pos;
    logic signed [31:0] n_vel;

    // stage 1
    logic signed [31:0] r1_pos, r1_vel, r1_force, r1_vdt, r1_wrap;
    // stage 2
    logic signed [31:0] r2_pos, r2_vel, r2_k, r2_vdt, r2_wrap;
    // stage 3
    logic signed [31:0] r3_pos, r3_vel, r3_vk, r3_kdt, r3_vdt, r3_wrap;
    // stage 4
    logic signed [31:0] r4_pos, r4_vel, r4_vk, r4_d, r4_wrap;
    // output stage
    logic signed [31:0] r_new_pos, r_new_vel;

    assign w_dt_s   = $signed({1'b0, i_dt});
    assign w_box33  = $signed({2'b00, i_box});
    assign w_half33 = $signed({2'b00, i_half});

    // Wrap, first half: above the threshold subtracts one cell length
    assign w_in_pos33 = {i_pos[31], i_pos};
    always_comb begin
        if (w_in_pos33 > w_half33) begin
            n_wrap1 = vva_pkg::sat33(w_in_pos33 - w_box33);
        end else begin
            n_wrap1 = i_pos;
        end
    end

    // Wrap, second half: below minus the threshold adds one cell length
    assign w_r1_wrap33 = {r1_wrap[31], r1_wrap};
    always_comb begin
        if (w_r1_wrap33 < -w_half33) begin
            n_wrap2 = vva_pkg::sat33(w_r1_wrap33 + w_box33);
        end else begin
            n_wrap2 = r1_wrap;
        end
    end

    // Final select by function code
    always_comb begin
        unique case (i_ctl.func)
            vva_pkg::FUNC_DRIFT: begin
                n_pos = vva_pkg::sat33({r4_pos[31], r4_pos} + {r4_d[31], r4_d});
                n_vel = r4_vk;
            end
            vva_pkg::FUNC_KICK: begin
                n_pos = r4_pos;
                n_vel = r4_vk;
            end
            vva_pkg::FUNC_WRAP: begin
                n_pos = r4_wrap;
                n_vel = r4_vel;
            end
            vva_pkg::FUNC_PASS: begin
                n_pos = r4_pos;
                n_vel = r4_vel;
            end
            default: begin
                n_pos = r4_pos;
                n_vel = r4_vel;
            end
        endcase
    end

    // Pipeline registers, all advance together
    always_ff @(posedge i_clk) begin
        if (i_ctl.en) begin
            // stage 1: v*dt, first wrap compare
            r1_pos   <= i_pos;
            r1_vel   <= i_vel;
            r1_force <= i_force;
            r1_vdt   <= vva_pkg::qmul(i_vel, w_dt_s);
            r1_wrap  <= n_wrap1;
            // stage 2: k = c*f, second wrap compare
            r2_pos   <= r1_pos;
            r2_vel   <= r1_vel;
            r2_k     <= vva_pkg::qmul($signed({1'b0, i_c}), r1_force);
            r2_vdt   <= r1_vdt;
            r2_wrap  <= n_wrap2;
            // stage 3: k*dt, v+k
            r3_pos   <= r2_pos;
            r3_vel   <= r2_vel;
            r3_vk    <= vva_pkg::sat33({r2_vel[31], r2_vel} + {r2_k[31], r2_k});
            r3_kdt   <= vva_pkg::qmul(r2_k, w_dt_s);
            r3_vdt   <= r2_vdt;
            r3_wrap  <= r2_wrap;
            // stage 4: displacement
            r4_pos   <= r3_pos;
            r4_vel   <= r3_vel;
            r4_vk    <= r3_vk;
            r4_d     <= vva_pkg::sat33({r3_vdt[31], r3_vdt} + {r3_kdt[31], r3_kdt});
            r4_wrap  <= r3_wrap;
            // output stage
            r_new_pos <= n_pos;
            r_new_vel <= n_vel;
        end
    end

    assign o_new_pos = r_new_pos;
    assign o_new_vel = r_new_vel;

endmodule

// File: rtl/velocity_verlet_atom_step.sv
// Top level of the velocity Verlet atom step: config registers, control pipeline, axes.
`timescale 1ns / 1ps

// One atom enters per cycle while no finished result is stalled at the output (five register
// stages: v*dt and the cell wrap, c*force, k*dt and v+k, displacement, output select).
// The half-kick factor c = (inverse_mass * time_step) >> 17 is formed in stage 1 from
// the configuration registers, so config written while the block is idle is used by
// the next atom. The whole pipeline holds while a finished result is stalled at the
// output; bubbles inside the pipeline are kept. Values are signed Q16.16; products are
// truncated toward minus infinity and every product and sum saturates to 32 bits.
module velocity_verlet_atom_step (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // configuration write port
    input  logic                i_cfg_we,
    input  logic [1:0]          i_cfg_idx,
    input  logic [30:0]         i_cfg_data,
    // input channel
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  logic [1:0]          i_func,
    input  logic signed [31:0]  i_pos_x,
    input  logic signed [31:0]  i_pos_y,
    input  logic signed [31:0]  i_pos_z,
    input  logic signed [31:0]  i_vel_x,
    input  logic signed [31:0]  i_vel_y,
    input  logic signed [31:0]  i_vel_z,
    input  logic signed [31:0]  i_force_x,
    input  logic signed [31:0]  i_force_y,
    input  logic signed [31:0]  i_force_z,
    input  logic                i_last_atom,
    // output channel
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output logic signed [31:0]  o_new_pos_x,
    output logic signed [31:0]  o_new_pos_y,
    output logic signed [31:0]  o_new_pos_z,
    output logic signed [31:0]  o_new_vel_x,
    output logic signed [31:0]  o_new_vel_y,
    output logic signed [31:0]  o_new_vel_z,
    output logic                o_sweep_done
);

    localparam int unsigned D = vva_pkg::PIPE_DEPTH;

    logic [30:0]            r_inv_mass;
    logic [30:0]            r_time_step;
    logic [30:0]            r_box_len;
    logic [30:0]            r_half_box;
    logic [D-1:0]           r_vld;
    logic [D-1:0]           r_last;
    vva_pkg::t_func         r_func [D-1];
    logic [30:0]            r_c;
    logic [61:0]            w_cprod;
    logic [30:0]            n_c;
    logic                   w_en;
    vva_pkg::t_axis_ctl     w_ctl;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inv_mass  <= 31'd65536;
            r_time_step <= 31'd655;
            r_box_len   <= 31'd655360;
            r_half_box  <= 31'd327680;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                vva_pkg::REG_INV_MASS:  r_inv_mass  <= i_cfg_data;
                vva_pkg::REG_TIME_STEP: r_time_step <= i_cfg_data;
                vva_pkg::REG_BOX_LEN:   r_box_len   <= i_cfg_data;
                vva_pkg::REG_HALF_BOX:  r_half_box  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Pipeline advances unless a finished result is stalled
    assign w_en        = !(r_vld[D-1] && i_out_stall);
    assign o_in_stall  = r_vld[D-1] && i_out_stall;

    // Half-kick factor, 0.5 folded into the shift
    assign w_cprod = 62'(r_inv_mass) * 62'(r_time_step);
    assign n_c     = (w_cprod[61:48] != 14'd0) ? 31'h7fff_ffff : w_cprod[47:17];

    // Valid, function and sweep-end tags travel with the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[D-2:0], i_in_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_last    <= {r_last[D-2:0], i_last_atom};
            r_func[0] <= vva_pkg::t_func'(i_func);
            for (int i = 1; i < D - 1; i++) begin
                r_func[i] <= r_func[i-1];
            end
            r_c <= n_c;
        end
    end

    assign w_ctl.en   = w_en;
    assign w_ctl.func = r_func[D-2];

    vva_axis u_axis_x (
        .i_clk(i_clk), .i_ctl(w_ctl),
        .i_pos(i_pos_x), .i_vel(i_vel_x), .i_force(i_force_x),
        .i_c(r_c), .i_dt(r_time_step), .i_box(r_box_len), .i_half(r_half_box),
        .o_new_pos(o_new_pos_x), .o_new_vel(o_new_vel_x)
    );

    vva_axis u_axis_y (
        .i_clk(i_clk), .i_ctl(w_ctl),
        .i_pos(i_pos_y), .i_vel(i_vel_y), .i_force(i_force_y),
        .i_c(r_c), .i_dt(r_time_step), .i_box(r_box_len), .i_half(r_half_box),
        .o_new_pos(o_new_pos_y), .o_new_vel(o_new_vel_y)
    );

    vva_axis u_axis_z (
        .i_clk(i_clk), .i_ctl(w_ctl),
        .i_pos(i_pos_z), .i_vel(i_vel_z), .i_force(i_force_z),
        .i_c(r_c), .i_dt(r_time_step), .i_box(r_box_len), .i_half(r_half_box),
        .o_new_pos(o_new_pos_z), .o_new_vel(o_new_vel_z)
    );

    assign o_out_valid  = r_vld[D-1];
    assign o_sweep_done = r_last[D-1];

`ifndef SYNTHESIS
    // a stalled result must hold the input side
    a_stall_back: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |-> o_in_stall)
        else $error("input not stalled while result is held");

    // an accepted transfer enters the first stage
    a_enter: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> r_vld[0])
        else $error("accepted item lost at entry");

    // an item in stage four reaches the output when the pipe advances
    a_reach_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[D-2] && !o_in_stall) |=> o_out_valid)
        else $error("item lost before output");
`endif

endmodule
